// ===== src/orb_pkg.sv =====
// Shared types and constants for the orbit step block.
`default_nettype none
package orb_pkg;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic         start;
    alu_op_t      op;
    logic [7:0]   cnt;
    logic [127:0] a;
    logic [127:0] b;
  } alu_req_t;

  localparam logic [1:0] REG_GRAV      = 2'd0;
  localparam logic [1:0] REG_MAX_DT    = 2'd1;
  localparam logic [1:0] REG_SPEED     = 2'd2;

  localparam logic [49:0] GRAV_RESET  = 50'd398600441800000;
  localparam logic [23:0] MAX_DT_RESET = 24'd104858;
  localparam logic [23:0] SPEED_RESET  = 24'd256;

  localparam logic [7:0] DIV_STEPS  = 8'd128;
  localparam logic [7:0] SQRT_STEPS = 8'd49;
  localparam int unsigned SQRT_ALIGN = 30;

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic [48:0] mag49(input logic signed [48:0] v);
    return v[48] ? 49'(-v) : 49'(v);
  endfunction

endpackage
`default_nettype wire

// ===== src/orb_if.sv =====
// Step and result channel interfaces.
`default_nettype none
interface orb_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [23:0]        frame_dt;
  logic signed [47:0] load_px;
  logic signed [47:0] load_py;
  logic signed [47:0] load_pz;
  logic signed [47:0] load_vx;
  logic signed [47:0] load_vy;
  logic signed [47:0] load_vz;
  modport source(output valid, op, frame_dt, load_px, load_py, load_pz,
                 load_vx, load_vy, load_vz, input ready);
  modport sink(input valid, op, frame_dt, load_px, load_py, load_pz,
               load_vx, load_vy, load_vz, output ready);
endinterface

interface orb_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [47:0] pos_z;
  logic signed [47:0] vel_x;
  logic signed [47:0] vel_y;
  logic signed [47:0] vel_z;
  logic [47:0]        radius;
  logic               error;
  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 radius, error, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               radius, error, output ready);
endinterface
`default_nettype wire

// ===== src/orb_alu.sv =====
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
`default_nettype none
module orb_alu import orb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire alu_req_t     req,
  output logic              done,
  output logic [127:0]      res
);

  logic         busy;
  alu_op_t      op_q;
  logic [7:0]   cnt;
  logic [127:0] x;
  logic [127:0] y;
  logic [127:0] acc;
  logic [127:0] q;

  logic [128:0] div_rem;
  logic         div_ge;
  logic [128:0] div_sub;
  logic [129:0] sq_rem;
  logic [129:0] sq_trial;
  logic         sq_ge;
  logic [129:0] sq_sub;

  always_comb begin
    div_rem  = {acc, x[127]};
    div_ge   = div_rem >= {1'b0, y};
    div_sub  = div_rem - {1'b0, y};
    sq_rem   = {acc, x[127:126]};
    sq_trial = {q, 2'b01};
    sq_ge    = sq_rem >= sq_trial;
    sq_sub   = sq_rem - sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && cnt == 8'd1;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 8'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q <= req.op;
      acc  <= '0;
      q    <= '0;
      y    <= req.b;
      case (req.op)
        ALU_MUL: begin
          x   <= req.a;
          cnt <= req.cnt;
        end
        ALU_DIV: begin
          x   <= req.a;
          cnt <= DIV_STEPS;
        end
        ALU_SQRT: begin
          x   <= req.a << SQRT_ALIGN;
          cnt <= SQRT_STEPS;
        end
        default: begin
          x   <= req.a;
          cnt <= 8'd1;
        end
      endcase
    end else if (busy) begin
      cnt <= cnt - 8'd1;
      case (op_q)
        ALU_MUL: begin
          if (y[0]) acc <= acc + x;
          x <= x << 1;
          y <= y >> 1;
        end
        ALU_DIV: begin
          if (div_ge) begin
            acc <= div_sub[127:0];
            x   <= {x[126:0], 1'b1};
          end else begin
            acc <= div_rem[127:0];
            x   <= {x[126:0], 1'b0};
          end
        end
        ALU_SQRT: begin
          if (sq_ge) begin
            acc <= sq_sub[127:0];
            q   <= {q[126:0], 1'b1};
          end else begin
            acc <= sq_rem[127:0];
            q   <= {q[126:0], 1'b0};
          end
          x <= x << 2;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  always_comb begin
    case (op_q)
      ALU_DIV:  res = x;
      ALU_SQRT: res = q;
      default:  res = acc;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/orbit_verlet_gravity_step.sv =====
// Advance: two gravity passes (each a 128-step GM/r^2 divide, a 49-step root and three
// multiply/128-step divide pairs, all on one shared unit); cut short when the starting
// radius is zero.
// Load: sum of squares and root for the radius.
// One item at a time: ready only when idle, result held until taken.
// Reset (synchronous): registers to defaults, position and velocity zero, idle.
`default_nettype none
module orbit_verlet_gravity_step import orb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  orb_in_if.sink           step_in,
  orb_out_if.source        step_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [49:0] cfg_data
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_HMUL  = 17'h00002,
    S_SQ    = 17'h00004,
    S_SQCHK = 17'h00008,
    S_GDIV  = 17'h00010,
    S_RT    = 17'h00020,
    S_GMUL  = 17'h00040,
    S_GQ    = 17'h00080,
    S_PINIT = 17'h00100,
    S_PV    = 17'h00200,
    S_PA1   = 17'h00400,
    S_PA2   = 17'h00800,
    S_VINIT = 17'h01000,
    S_VA    = 17'h02000,
    S_ABS   = 17'h04000,
    S_RND   = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  state_t state;

  logic [49:0] grav_parameter;
  logic [23:0] max_dt;
  logic [23:0] speed_mult;

  logic signed [47:0] pos [3];
  logic signed [47:0] vel [3];
  logic signed [47:0] np [3];
  logic signed [47:0] aold [3];
  logic signed [47:0] anew [3];

  logic [23:0]         dtc;
  logic [39:0]         h;
  logic [95:0]         s;
  logic [63:0]         g;
  logic [48:0]         r;
  logic [111:0]        tmp;
  logic signed [129:0] acc;
  logic                accneg;
  logic [1:0]          idx;
  logic                phase;
  logic                is_load;
  logic                err;
  logic                issued;

  alu_req_t     req;
  logic         alu_done;
  logic [127:0] alu_res;

  orb_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (alu_done),
    .res  (alu_res)
  );

  logic signed [47:0]  pcur;
  logic [47:0]         pmag;
  logic signed [48:0]  as_sum;
  logic [46:0]         a_m;
  logic signed [47:0]  a_val;
  logic [129:0]        term;
  logic                term_neg;
  logic signed [129:0] acc_add;
  logic [129:0]        rnd_sum;
  logic [129:0]        rnd_q;
  logic [129:0]        rnd_lim;
  logic [47:0]         rnd_m;
  logic signed [47:0]  rnd_val;

  always_comb begin
    pcur   = phase ? np[idx] : pos[idx];
    pmag   = mag48(pcur);
    as_sum = {aold[idx][47], aold[idx]} + {anew[idx][47], anew[idx]};
    a_m    = (|alu_res[127:47]) ? {47{1'b1}} : alu_res[46:0];
    a_val  = pcur[47] ? $signed({1'b0, a_m}) : -$signed({1'b0, a_m});

    term     = '0;
    term_neg = 1'b0;
    case (state)
      S_PINIT: begin
        term     = {33'd0, mag48(pos[idx]), 49'd0};
        term_neg = pos[idx][47];
      end
      S_PV: begin
        term     = {alu_res[108:0], 21'd0};
        term_neg = vel[idx][47];
      end
      S_PA2: begin
        term     = {2'd0, alu_res};
        term_neg = aold[idx][47];
      end
      S_VINIT: begin
        term     = {61'd0, mag48(vel[idx]), 21'd0};
        term_neg = vel[idx][47];
      end
      S_VA: begin
        term     = {2'd0, alu_res};
        term_neg = as_sum[48];
      end
      default: begin
        term     = '0;
        term_neg = 1'b0;
      end
    endcase
    // init states start from zero, the others add to the running sum
    if (state == S_PINIT || state == S_VINIT) begin
      acc_add = term_neg ? -$signed(term) : $signed(term);
    end else begin
      acc_add = term_neg ? acc - $signed(term) : acc + $signed(term);
    end

    // round half away from zero, then saturate
    rnd_sum = phase ? 130'(acc) + (130'd1 << 20) : 130'(acc) + (130'd1 << 48);
    rnd_q   = phase ? rnd_sum >> 21 : rnd_sum >> 49;
    rnd_lim = accneg ? (130'd1 << 47) : (130'd1 << 47) - 130'd1;
    rnd_m   = (rnd_q > rnd_lim) ? rnd_lim[47:0] : rnd_q[47:0];
    rnd_val = accneg ? -$signed(rnd_m) : $signed(rnd_m);
  end

  always_comb begin
    req       = '0;
    req.op    = ALU_MUL;
    req.cnt   = 8'd48;
    case (state)
      S_HMUL: begin
        req.a   = {104'd0, dtc};
        req.b   = {104'd0, speed_mult};
        req.cnt = 8'd24;
      end
      S_SQ: begin
        req.a = {80'd0, pmag};
        req.b = {80'd0, pmag};
      end
      S_GDIV: begin
        req.op = ALU_DIV;
        req.a  = {22'd0, grav_parameter, 56'd0};
        req.b  = {32'd0, s};
      end
      S_RT: begin
        req.op = ALU_SQRT;
        req.a  = {32'd0, s};
      end
      S_GMUL: begin
        req.a = {64'd0, g};
        req.b = {80'd0, pmag};
      end
      S_GQ: begin
        req.op = ALU_DIV;
        req.a  = {16'd0, tmp};
        req.b  = {79'd0, r};
      end
      S_PV: begin
        req.a   = {80'd0, mag48(vel[idx])};
        req.b   = {88'd0, h};
        req.cnt = 8'd40;
      end
      S_PA1: begin
        req.a   = {80'd0, mag48(aold[idx])};
        req.b   = {88'd0, h};
        req.cnt = 8'd40;
      end
      S_PA2: begin
        req.a   = {16'd0, tmp};
        req.b   = {88'd0, h};
        req.cnt = 8'd40;
      end
      S_VA: begin
        req.a   = {79'd0, mag49(as_sum)};
        req.b   = {88'd0, h};
        req.cnt = 8'd40;
      end
      default: begin
        req.a = '0;
        req.b = '0;
      end
    endcase
    req.start = !issued && (state inside {S_HMUL, S_SQ, S_GDIV, S_RT, S_GMUL, S_GQ,
                                          S_PV, S_PA1, S_PA2, S_VA});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_parameter <= GRAV_RESET;
      max_dt         <= MAX_DT_RESET;
      speed_mult     <= SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRAV:   grav_parameter <= cfg_data;
        REG_MAX_DT: max_dt <= cfg_data[23:0];
        REG_SPEED:  speed_mult <= cfg_data[23:0];
        default:    grav_parameter <= grav_parameter;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
      idx    <= 2'd0;
      phase  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        pos[k] <= '0;
        vel[k] <= '0;
      end
    end else begin
      if (req.start) issued <= 1'b1;
      case (state)
        S_IDLE: begin
          if (step_in.valid) begin
            idx     <= 2'd0;
            phase   <= 1'b0;
            s       <= '0;
            err     <= 1'b0;
            is_load <= step_in.op;
            dtc     <= (step_in.frame_dt > max_dt) ? max_dt : step_in.frame_dt;
            if (step_in.op) begin
              pos[0] <= step_in.load_px;
              pos[1] <= step_in.load_py;
              pos[2] <= step_in.load_pz;
              vel[0] <= step_in.load_vx;
              vel[1] <= step_in.load_vy;
              vel[2] <= step_in.load_vz;
              state  <= S_SQ;
            end else begin
              state <= S_HMUL;
            end
          end
        end
        S_HMUL: begin
          if (alu_done) begin
            issued <= 1'b0;
            h      <= alu_res[47:8];
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          if (alu_done) begin
            issued <= 1'b0;
            s      <= s + alu_res[95:0];
            if (idx == 2'd2) begin
              idx   <= 2'd0;
              state <= S_SQCHK;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        S_SQCHK: begin
          if (is_load) begin
            state <= S_RT;
          end else if (s == '0) begin
            // zero radius: skip, keep state; before the step the radius reads 0
            err <= 1'b1;
            if (!phase) r <= '0;
            state <= S_OUT;
          end else begin
            state <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (alu_done) begin
            issued <= 1'b0;
            g      <= (|alu_res[127:64]) ? {64{1'b1}} : alu_res[63:0];
            state  <= S_RT;
          end
        end
        S_RT: begin
          if (alu_done) begin
            issued <= 1'b0;
            r      <= alu_res[48:0];
            idx    <= 2'd0;
            state  <= is_load ? S_OUT : S_GMUL;
          end
        end
        S_GMUL: begin
          if (alu_done) begin
            issued <= 1'b0;
            tmp    <= alu_res[111:0];
            state  <= S_GQ;
          end
        end
        S_GQ: begin
          if (alu_done) begin
            issued <= 1'b0;
            if (phase) anew[idx] <= a_val;
            else aold[idx] <= a_val;
            if (idx == 2'd2) begin
              idx   <= 2'd0;
              state <= phase ? S_VINIT : S_PINIT;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_GMUL;
            end
          end
        end
        S_PINIT: begin
          acc   <= acc_add;
          state <= S_PV;
        end
        S_PV: begin
          if (alu_done) begin
            issued <= 1'b0;
            acc    <= acc_add;
            state  <= S_PA1;
          end
        end
        S_PA1: begin
          if (alu_done) begin
            issued <= 1'b0;
            tmp    <= alu_res[111:0];
            state  <= S_PA2;
          end
        end
        S_PA2: begin
          if (alu_done) begin
            issued <= 1'b0;
            acc    <= acc_add;
            state  <= S_ABS;
          end
        end
        S_VINIT: begin
          acc   <= acc_add;
          state <= S_VA;
        end
        S_VA: begin
          if (alu_done) begin
            issued <= 1'b0;
            acc    <= acc_add;
            state  <= S_ABS;
          end
        end
        S_ABS: begin
          accneg <= acc[129];
          acc    <= acc[129] ? -acc : acc;
          state  <= S_RND;
        end
        S_RND: begin
          if (!phase) begin
            np[idx] <= rnd_val;
            if (idx == 2'd2) begin
              idx   <= 2'd0;
              phase <= 1'b1;
              s     <= '0;
              state <= S_SQ;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_PINIT;
            end
          end else begin
            vel[idx] <= rnd_val;
            pos[idx] <= np[idx];
            if (idx == 2'd2) begin
              idx   <= 2'd0;
              state <= S_OUT;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_VINIT;
            end
          end
        end
        S_OUT: begin
          if (step_out.ready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign step_in.ready   = (state == S_IDLE);
  assign step_out.valid  = (state == S_OUT);
  assign step_out.pos_x  = pos[0];
  assign step_out.pos_y  = pos[1];
  assign step_out.pos_z  = pos[2];
  assign step_out.vel_x  = vel[0];
  assign step_out.vel_y  = vel[1];
  assign step_out.vel_z  = vel[2];
  assign step_out.radius = r[47:0];
  assign step_out.error  = err;

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    step_out.valid |-> !step_in.ready) else $error("input taken while result pending");

  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> issued) else $error("unit finished without a request");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd3) else $error("component index out of range");

  a_load_no_err: assert property (@(posedge clk) disable iff (rst)
    (step_out.valid && is_load) |-> !err) else $error("error flagged on load");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |=> !req.start) else $error("back to back unit requests");

endmodule
`default_nettype wire

// ===== bench/tb_orbit_verlet_gravity_step.sv =====
// Self-checking bench for the orbit step block: random and directed load/advance beats.
`default_nettype none
module tb_orbit_verlet_gravity_step import orb_pkg::*;;

  typedef struct {
    logic               op;
    logic [23:0]        dt;
    logic signed [47:0] lp[3];
    logic signed [47:0] lv[3];
  } step_item_t;

  typedef struct {
    logic signed [47:0] pos[3];
    logic signed [47:0] vel[3];
    logic [47:0]        radius;
    logic               error;
  } orbit_state_t;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;
  localparam int   STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GRAV;
  logic [49:0] cfg_data = '0;

  orb_in_if  step_in();
  orb_out_if step_out();

  orbit_verlet_gravity_step dut (
    .clk(clk), .rst(rst), .step_in(step_in), .step_out(step_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bench copy of block state and registers
  logic [49:0]        gm_q = GRAV_RESET;
  logic [23:0]        max_dt_q = MAX_DT_RESET;
  logic [23:0]        speed_q = SPEED_RESET;
  logic signed [47:0] sat_pos[3] = '{default: '0};
  logic signed [47:0] sat_vel[3] = '{default: '0};

  step_item_t   pending_steps[$];
  orbit_state_t expected_states[$];
  bit           in_flight = 0;
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;

  function automatic logic [63:0] mag(input logic signed [47:0] v);
    logic [47:0] m;
    m = v[47] ? -v : v;
    return 64'(m);
  endfunction

  function automatic logic [127:0] sum_sq(input logic signed [47:0] p[3]);
    logic [127:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) s += 128'(mag(p[i])) * 128'(mag(p[i]));
    return s;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] s);
    logic [127:0] r, c;
    r = '0;
    for (int b = 48; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  // point-mass pull toward the origin, Q23.24 per axis
  function automatic void pull(input logic signed [47:0] p[3], input logic [127:0] s,
                               output logic signed [47:0] a[3]);
    logic [127:0] g, r, q;
    g = ({78'd0, gm_q} << 56) / s;
    if (g > 128'hFFFF_FFFF_FFFF_FFFF) g = 128'hFFFF_FFFF_FFFF_FFFF;
    r = 128'(int_sqrt(s));
    for (int i = 0; i < 3; i++) begin
      q = (g * 128'(mag(p[i]))) / r;
      if (q > 128'h7FFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF;
      a[i] = p[i][47] ? 48'(q) : -48'(q);
    end
  endfunction

  // round half away from zero by n bits, saturate to 48 bits
  function automatic logic signed [47:0] round_sat(input logic signed [135:0] x, input int n);
    logic [135:0] m, lim;
    logic neg;
    neg = x < 0;
    m = neg ? -x : x;
    m = (m + (136'd1 << (n - 1))) >> n;
    lim = neg ? 136'h8000_0000_0000 : 136'h7FFF_FFFF_FFFF;
    if (m > lim) m = lim;
    return neg ? -48'(m) : 48'(m);
  endfunction

  function automatic orbit_state_t verlet_step(input step_item_t it);
    orbit_state_t res;
    logic [23:0] dt;
    logic [47:0] h;
    logic [127:0] s0, s1;
    logic signed [47:0] a_old[3], a_new[3], np[3];
    logic signed [135:0] t, x, hs;
    res.error = 1'b0;
    if (it.op == OP_LOAD) begin
      sat_pos = it.lp;
      sat_vel = it.lv;
    end else begin
      dt = (it.dt > max_dt_q) ? max_dt_q : it.dt;
      h = (48'(dt) * 48'(speed_q)) >> 8;
      hs = 136'(h);
      s0 = sum_sq(sat_pos);
      if (s0 == 0) begin
        res.error = 1'b1;
      end else begin
        pull(sat_pos, s0, a_old);
        for (int i = 0; i < 3; i++) begin
          t = sat_pos[i];
          t = t <<< 49;
          x = sat_vel[i];
          t += (x * hs) <<< 21;
          x = a_old[i];
          t += x * hs * hs;
          np[i] = round_sat(t, 49);
        end
        s1 = sum_sq(np);
        if (s1 == 0) begin
          res.error = 1'b1;
        end else begin
          pull(np, s1, a_new);
          for (int i = 0; i < 3; i++) begin
            t = sat_vel[i];
            t = t <<< 21;
            x = a_old[i];
            x += a_new[i];
            t += x * hs;
            sat_vel[i] = round_sat(t, 21);
            sat_pos[i] = np[i];
          end
        end
      end
    end
    res.pos = sat_pos;
    res.vel = sat_vel;
    res.radius = 48'(int_sqrt(sum_sq(sat_pos)));
    return res;
  endfunction

  // driver, and prediction on each accepted step beat
  always @(posedge clk) begin
    step_item_t it;
    if (rst) begin
      step_in.valid <= 1'b0;
      step_in.op <= OP_ADVANCE;
      step_in.frame_dt <= '0;
      {step_in.load_px, step_in.load_py, step_in.load_pz} <= '0;
      {step_in.load_vx, step_in.load_vy, step_in.load_vz} <= '0;
    end else begin
      if (step_in.valid && step_in.ready) begin
        it.op = step_in.op;
        it.dt = step_in.frame_dt;
        it.lp = '{step_in.load_px, step_in.load_py, step_in.load_pz};
        it.lv = '{step_in.load_vx, step_in.load_vy, step_in.load_vz};
        expected_states.push_back(verlet_step(it));
        in_flight = 0;
      end
      if (!step_in.valid || step_in.ready) begin
        if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_steps.pop_front();
          in_flight = 1;
          step_in.valid <= 1'b1;
          step_in.op <= it.op;
          step_in.frame_dt <= it.dt;
          step_in.load_px <= it.lp[0];
          step_in.load_py <= it.lp[1];
          step_in.load_pz <= it.lp[2];
          step_in.load_vx <= it.lv[0];
          step_in.load_vy <= it.lv[1];
          step_in.load_vz <= it.lv[2];
        end else begin
          step_in.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    orbit_state_t e;
    logic signed [47:0] got_p[3], got_v[3];
    if (rst) begin
      step_out.ready <= 1'b0;
    end else begin
      if (step_out.valid && step_out.ready) begin
        if (expected_states.size() == 0) begin
          $error("result beat with no step pending");
          fail_count++;
        end else begin
          e = expected_states.pop_front();
          got_p = '{step_out.pos_x, step_out.pos_y, step_out.pos_z};
          got_v = '{step_out.vel_x, step_out.vel_y, step_out.vel_z};
          for (int i = 0; i < 3; i++) begin
            if (got_p[i] !== e.pos[i]) begin
              $error("pos[%0d] expected %0d got %0d", i, e.pos[i], got_p[i]);
              fail_count++;
            end
            if (got_v[i] !== e.vel[i]) begin
              $error("vel[%0d] expected %0d got %0d", i, e.vel[i], got_v[i]);
              fail_count++;
            end
          end
          if (step_out.radius !== e.radius) begin
            $error("radius expected %0d got %0d", e.radius, step_out.radius);
            fail_count++;
          end
          if (step_out.error !== e.error) begin
            $error("error expected %0b got %0b", e.error, step_out.error);
            fail_count++;
          end
        end
      end
      step_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((step_in.valid && step_in.ready) || (step_out.valid && step_out.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL orbit_verlet_gravity_step");
        $finish;
      end
    end
  end

  function automatic logic signed [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic void add_load(input logic signed [47:0] px, py, pz, vx, vy, vz);
    step_item_t it;
    it.op = OP_LOAD;
    it.dt = 24'($urandom);
    it.lp = '{px, py, pz};
    it.lv = '{vx, vy, vz};
    pending_steps.push_back(it);
  endfunction

  function automatic void add_advance(input logic [23:0] dt);
    step_item_t it;
    it.op = OP_ADVANCE;
    it.dt = dt;
    it.lp = '{rand48(), rand48(), rand48()};
    it.lv = '{rand48(), rand48(), rand48()};
    pending_steps.push_back(it);
  endfunction

  // meters or m/s scaled into fixed point, random sign and fraction
  function automatic logic signed [47:0] fixed_rand(input int whole_max, input int frac_bits);
    logic signed [47:0] v;
    v = (48'($urandom_range(whole_max)) << frac_bits) | 48'($urandom_range((1 << frac_bits) - 1));
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic void add_orbit_load();
    add_load(fixed_rand(40000000, 16), fixed_rand(40000000, 16), fixed_rand(40000000, 16),
             fixed_rand(9000, 24), fixed_rand(9000, 24), fixed_rand(9000, 24));
  endfunction

  task automatic wait_idle();
    while (pending_steps.size() > 0 || in_flight || expected_states.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(input logic [49:0] gm, input logic [23:0] mdt,
                            input logic [23:0] spd);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_GRAV; cfg_data <= gm;
    @(posedge clk);
    cfg_index <= REG_MAX_DT; cfg_data <= 50'(mdt);
    @(posedge clk);
    cfg_index <= REG_SPEED; cfg_data <= 50'(spd);
    @(posedge clk);
    cfg_we <= 1'b0;
    gm_q = gm;
    max_dt_q = mdt;
    speed_q = spd;
  endtask

  initial begin
    int pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers
    add_advance(24'd104858);  // nothing loaded yet, position at origin
    add_load('0, '0, '0, '0, '0, '0);
    add_advance(24'd1000);
    add_load(48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
             48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF);
    add_advance(24'hFFFFFF);
    add_load(48'sh8000_0000_0000, 48'sh8000_0000_0000, 48'sh8000_0000_0000,
             48'sh8000_0000_0000, 48'sh8000_0000_0000, 48'sh8000_0000_0000);
    add_advance(24'd0);
    add_load(48'sd7000000 <<< 16, '0, '0, '0, 48'sd7546 <<< 24, '0);
    add_advance(24'd104858);
    add_advance(24'd1);
    add_advance(24'hFFFFFF);
    // directed: no gravity, step lands exactly on the origin
    write_regs('0, 24'h100000, SPEED_RESET);
    add_load(48'sd1, '0, '0, -48'sd256, '0, '0);
    add_advance(24'h100000);
    add_advance(24'd5);
    // directed: register extremes
    write_regs(50'h3_FFFF_FFFF_FFFF, '0, 24'hFFFFFF);
    add_load(48'sd7000000 <<< 16, '0, '0, '0, 48'sd7546 <<< 24, '0);
    add_advance(24'hFFFFFF);
    write_regs(50'h3_FFFF_FFFF_FFFF, 24'hFFFFFF, '0);
    add_advance(24'hFFFFFF);
    write_regs(50'h3_FFFF_FFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_load(fixed_rand(40000000, 16), '0, '0, '0, fixed_rand(9000, 24), '0);
    add_advance(24'hFFFFFF);

    // random phases: idle mode and register setting per phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_regs(GRAV_RESET, MAX_DT_RESET, SPEED_RESET);
        1: write_regs(50'({$urandom, $urandom}), 24'($urandom), 24'($urandom_range(4096)));
        2: write_regs(50'h3_FFFF_FFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF);
        default: write_regs(50'($urandom) << $urandom_range(18), 24'($urandom_range(1 << 22)),
                            24'($urandom_range(2560)));
      endcase
      send_idle_pct = (ph == 1 || ph == 3) ? 46 : 0;
      recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 38 : 0;
      if (ph == 3) send_idle_pct = 38;
      add_orbit_load();
      for (int n = 0; n < 150; n++) begin
        pick = $urandom_range(99);
        if (pick < 8)
          add_orbit_load();
        else if (pick < 16)
          add_load(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
        else if (pick < 26)
          add_advance(24'($urandom));
        else
          add_advance(24'($urandom_range(2 * max_dt_q)));
        // sender holds off until the block has drained
        if (n == 75) wait_idle();
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_states.size() == 0)
      $display("PASS orbit_verlet_gravity_step");
    else
      $display("FAIL orbit_verlet_gravity_step");
    $finish;
  end

endmodule
`default_nettype wire
